### sv/otl_pkg.sv
package otl_pkg;

	// Payload field widths
	localparam int FUNC_W   = 3;
	localparam int ITEM_W   = 16;
	localparam int GROUP_W  = 8;
	localparam int INDEX_W  = 6;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;

	// Operation codes
	localparam logic [FUNC_W-1:0] FN_ADD    = 3'd0;
	localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd1;
	localparam logic [FUNC_W-1:0] FN_QUERY  = 3'd2;
	localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd3;
	localparam logic [FUNC_W-1:0] FN_READ   = 3'd4;

	// Status codes
	localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_RANGE     = 2'd3;

endpackage

### sv/otl_req_if.sv
interface otl_req_if;
	logic                          valid;
	logic                          ready;
	logic [otl_pkg::FUNC_W-1:0]    func;
	logic [otl_pkg::ITEM_W-1:0]    item_id;
	logic [otl_pkg::GROUP_W-1:0]   group_id;
	logic [otl_pkg::INDEX_W-1:0]   entry_index;

	modport source (output valid, func, item_id, group_id, entry_index, input ready);
	modport sink (input valid, func, item_id, group_id, entry_index, output ready);
endinterface

### sv/otl_rsp_if.sv
interface otl_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [otl_pkg::STATUS_W-1:0]  status;
	logic                          found;
	logic                          group_tagged;
	logic                          group_changed;
	logic [otl_pkg::COUNT_W-1:0]   list_count;
	logic [otl_pkg::ITEM_W-1:0]    entry_item;
	logic [otl_pkg::GROUP_W-1:0]   entry_group;

	modport source (output valid, status, found, group_tagged, group_changed, list_count,
		entry_item, entry_group, input ready);
	modport sink (input valid, status, found, group_tagged, group_changed, list_count,
		entry_item, entry_group, output ready);
endinterface

### sv/otl_list_ram.sv
module otl_list_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 24
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one entry, read one entry with registered data
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### sv/ordered_tag_list_with_group_flags_core.sv
// Flow: an add to a list with room skips the scan and goes from acceptance straight to the
// done state; every other operation walks the list once before it returns its word.
// Throughput: one word at a time, the next accepted only back in idle, set by the
// single list memory read port and the one entry comparator that scans it.
// Reset (arst_n, asynchronous): list empty, no group tagged; list memory is not cleared.
module ordered_tag_list_with_group_flags_core #(
	parameter int LIST_DEPTH  = 64,
	parameter int GROUP_COUNT = 256,
	parameter int ITEM_BITS   = 16
) (
	input  logic clk,
	input  logic arst_n,
	otl_req_if.sink   req,
	otl_rsp_if.source rsp
);

	localparam int AW = $clog2(LIST_DEPTH);
	localparam int CW = $clog2(LIST_DEPTH + 1);
	localparam int IW = ITEM_BITS;
	localparam int GW = $clog2(GROUP_COUNT);
	localparam int EW = IW + GW;
	localparam logic [CW-1:0] FULL_CNT = CW'(LIST_DEPTH);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	// Reduce an 8-bit group id modulo GROUP_COUNT by restoring subtraction
	function automatic logic [GW-1:0] grp_reduce(input logic [otl_pkg::GROUP_W-1:0] g);
		logic [otl_pkg::GROUP_W-1:0] v;
		v = g;
		for (int k = otl_pkg::GROUP_W - 1; k >= 0; k--) begin
			if (32'(v) >= (32'(GROUP_COUNT) << k)) begin
				v = v - otl_pkg::GROUP_W'(32'(GROUP_COUNT) << k);
			end
		end
		return GW'(v);
	endfunction

	logic [1:0]                   state_q;
	logic [otl_pkg::FUNC_W-1:0]   func_q;
	logic [IW-1:0]                item_q;
	logic [GW-1:0]                grp_q;
	logic [otl_pkg::INDEX_W-1:0]  idx_q;
	logic                         add_ok_q;
	logic [CW-1:0]                cnt_q;
	logic [CW-1:0]                rd_cnt_q;
	logic                         rd_vld_s1;
	logic [CW-1:0]                rd_pos_s1;
	logic                         hit_q;
	logic                         oth_q;
	logic [IW-1:0]                ent_item_q;
	logic [GW-1:0]                ent_grp_q;
	logic [GROUP_COUNT-1:0]       flags_q;
	logic                         flag_q;

	logic                         out_vld_q;
	logic [otl_pkg::STATUS_W-1:0] out_status_q;
	logic                         out_found_q;
	logic                         out_tag_q;
	logic                         out_chg_q;
	logic [otl_pkg::COUNT_W-1:0]  out_cnt_q;
	logic [otl_pkg::ITEM_W-1:0]   out_item_q;
	logic [otl_pkg::GROUP_W-1:0]  out_grp_q;

	logic          acc;
	logic          add_ok;
	logic [GW-1:0] grp_in;
	logic          we;
	logic [AW-1:0] waddr;
	logic [EW-1:0] wdata;
	logic [EW-1:0] rdat_s1;
	logic [IW-1:0] rd_item;
	logic [GW-1:0] rd_grp;
	logic          load;

	logic [otl_pkg::STATUS_W-1:0] res_status;
	logic                         res_found;
	logic                         res_tag;
	logic                         res_chg;
	logic [CW-1:0]                res_cnt;
	logic [otl_pkg::ITEM_W-1:0]   res_item;
	logic [otl_pkg::GROUP_W-1:0]  res_grp;

	assign req.ready = (state_q == ST_IDLE);
	assign acc       = req.valid && req.ready;
	assign grp_in    = grp_reduce(req.group_id);
	assign add_ok    = (req.func == otl_pkg::FN_ADD) && (cnt_q < FULL_CNT);
	assign rd_item   = rdat_s1[EW-1:GW];
	assign rd_grp    = rdat_s1[GW-1:0];
	assign load      = (state_q == ST_DONE) && (!out_vld_q || rsp.ready);

	// Append on add, shift entries down by one behind a removed entry
	always_comb begin
		we    = 1'b0;
		waddr = cnt_q[AW-1:0];
		wdata = {IW'(req.item_id), grp_in};
		if (acc && add_ok) begin
			we = 1'b1;
		end else if (state_q == ST_SCAN && rd_vld_s1 && func_q == otl_pkg::FN_REMOVE
				&& hit_q) begin
			we    = 1'b1;
			waddr = AW'(rd_pos_s1 - 1'b1);
			wdata = rdat_s1;
		end
	end

	otl_list_ram #(
		.DEPTH (LIST_DEPTH),
		.WIDTH (EW)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (rd_cnt_q[AW-1:0]),
		.rdata (rdat_s1)
	);

	// Sequencer: accept, walk the list through the comparator unless an add has room, hand off the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			rd_cnt_q  <= '0;
			rd_vld_s1 <= 1'b0;
			hit_q     <= 1'b0;
			oth_q     <= 1'b0;
			add_ok_q  <= 1'b0;
		end else begin
			rd_vld_s1 <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						hit_q    <= 1'b0;
						oth_q    <= 1'b0;
						rd_cnt_q <= '0;
						add_ok_q <= add_ok;
						if (add_ok) begin
							cnt_q   <= cnt_q + 1'b1;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					// issue the next read
					if (rd_cnt_q < cnt_q) begin
						rd_vld_s1 <= 1'b1;
						rd_cnt_q  <= rd_cnt_q + 1'b1;
					end
					// compare the entry that came back
					if (rd_vld_s1) begin
						if (func_q == otl_pkg::FN_REMOVE && !hit_q && rd_item == item_q) begin
							hit_q <= 1'b1;
						end else begin
							if (rd_item == item_q) begin
								hit_q <= 1'b1;
							end
							if (rd_grp == grp_q) begin
								oth_q <= 1'b1;
							end
						end
					end
					if (rd_cnt_q == cnt_q && !rd_vld_s1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load) begin
						cnt_q   <= res_cnt;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Set a group flag on an add with room, settle it on a remove that hits, drop all flags on clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (acc && add_ok) begin
			flags_q[grp_in] <= 1'b1;
		end else if (load && func_q == otl_pkg::FN_REMOVE && hit_q) begin
			flags_q[grp_q] <= oth_q;
		end else if (load && func_q == otl_pkg::FN_CLEAR) begin
			flags_q <= '0;
		end
	end

	// Hold the request fields and the entry picked by a read
	always_ff @(posedge clk) begin
		if (acc) begin
			func_q <= req.func;
			item_q <= IW'(req.item_id);
			grp_q  <= grp_in;
			idx_q  <= req.entry_index;
			flag_q <= flags_q[grp_in];
		end
		if (state_q == ST_SCAN) begin
			rd_pos_s1 <= rd_cnt_q;
		end
		if (state_q == ST_SCAN && rd_vld_s1 && func_q == otl_pkg::FN_READ
				&& 32'(rd_pos_s1) == 32'(idx_q)) begin
			ent_item_q <= rd_item;
			ent_grp_q  <= rd_grp;
		end
	end

	// Build the result word from the scan flags
	always_comb begin
		res_status = otl_pkg::STAT_OK;
		res_found  = 1'b0;
		res_tag    = flag_q;
		res_chg    = 1'b0;
		res_cnt    = cnt_q;
		res_item   = '0;
		res_grp    = '0;
		case (func_q)
			otl_pkg::FN_ADD: begin
				if (add_ok_q) begin
					res_tag = 1'b1;
					res_chg = 1'b1;
				end else begin
					res_status = otl_pkg::STAT_FULL;
				end
			end
			otl_pkg::FN_REMOVE: begin
				if (hit_q) begin
					res_found = 1'b1;
					res_tag   = oth_q;
					res_chg   = flag_q && !oth_q;
					res_cnt   = cnt_q - 1'b1;
				end else begin
					res_status = otl_pkg::STAT_NOT_FOUND;
				end
			end
			otl_pkg::FN_QUERY: begin
				res_found = flag_q && hit_q;
			end
			otl_pkg::FN_CLEAR: begin
				res_chg = flag_q;
				res_tag = 1'b0;
				res_cnt = '0;
			end
			otl_pkg::FN_READ: begin
				if (32'(idx_q) < 32'(cnt_q)) begin
					res_item = otl_pkg::ITEM_W'(ent_item_q);
					res_grp  = otl_pkg::GROUP_W'(ent_grp_q);
				end else begin
					res_status = otl_pkg::STAT_RANGE;
				end
			end
			default: begin
			end
		endcase
	end

	// Output register: hold the word until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_status_q <= res_status;
			out_found_q  <= res_found;
			out_tag_q    <= res_tag;
			out_chg_q    <= res_chg;
			out_cnt_q    <= otl_pkg::COUNT_W'(res_cnt);
			out_item_q   <= res_item;
			out_grp_q    <= res_grp;
		end
	end

	assign rsp.valid         = out_vld_q;
	assign rsp.status        = out_status_q;
	assign rsp.found         = out_found_q;
	assign rsp.group_tagged  = out_tag_q;
	assign rsp.group_changed = out_chg_q;
	assign rsp.list_count    = out_cnt_q;
	assign rsp.entry_item    = out_item_q;
	assign rsp.entry_group   = out_grp_q;

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL_CNT)
		else $error("entry count above list depth");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> rd_cnt_q <= cnt_q)
		else $error("scan address past entry count");

	a_busy_after_acc: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> !req.ready)
		else $error("ready right after accepting a word");

	a_write_owner: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (acc || func_q == otl_pkg::FN_REMOVE))
		else $error("list write outside add or remove");

	a_notfound_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == otl_pkg::STAT_NOT_FOUND |-> !rsp.found)
		else $error("not found reported with found set");
`endif

endmodule
